### design/dtes_pkg.sv
package dtes_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [40:0] seconds;
        logic               status;
    } t_out_item;

    // one parsed date text, handed from the character front to the arithmetic back
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        bad;
    } t_job;

    localparam logic [31:0] EPOCH_OFFSET_RST  = 32'd6393600;
    localparam logic        STATUS_OK         = 1'b0;
    localparam logic        STATUS_BAD_LENGTH = 1'b1;

    localparam logic [3:0] MON_NONE = 4'd0;
    localparam logic [3:0] MON_JAN  = 4'd1;
    localparam logic [3:0] MON_FEB  = 4'd2;
    localparam logic [3:0] MON_MAR  = 4'd3;
    localparam logic [3:0] MON_APR  = 4'd4;
    localparam logic [3:0] MON_MAY  = 4'd5;
    localparam logic [3:0] MON_JUN  = 4'd6;
    localparam logic [3:0] MON_JUL  = 4'd7;
    localparam logic [3:0] MON_AUG  = 4'd8;
    localparam logic [3:0] MON_SEP  = 4'd9;
    localparam logic [3:0] MON_OCT  = 4'd10;
    localparam logic [3:0] MON_NOV  = 4'd11;
    localparam logic [3:0] MON_DEC  = 4'd12;

    function automatic logic [3:0] month_lookup(input logic [7:0] c0, input logic [7:0] c1,
                                                input logic [7:0] c2);
        logic [3:0] m;
        case ({c0, c1, c2})
            "Jan":   m = MON_JAN;
            "Feb":   m = MON_FEB;
            "Mar":   m = MON_MAR;
            "Apr":   m = MON_APR;
            "May":   m = MON_MAY;
            "Jun":   m = MON_JUN;
            "Jul":   m = MON_JUL;
            "Aug":   m = MON_AUG;
            "Sep":   m = MON_SEP;
            "Oct":   m = MON_OCT;
            "Nov":   m = MON_NOV;
            "Dec":   m = MON_DEC;
            default: m = MON_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            MON_FEB: d = 9'd31;
            MON_MAR: d = 9'd59;
            MON_APR: d = 9'd90;
            MON_MAY: d = 9'd120;
            MON_JUN: d = 9'd151;
            MON_JUL: d = 9'd181;
            MON_AUG: d = 9'd212;
            MON_SEP: d = 9'd243;
            MON_OCT: d = 9'd273;
            MON_NOV: d = 9'd304;
            MON_DEC: d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### design/dtes_front.sv
module dtes_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  dtes_pkg::t_in_item i_item,
    output logic            o_push,
    output dtes_pkg::t_job  o_job
);
    import dtes_pkg::*;

    localparam logic [4:0] POS_MON0 = 5'd0;
    localparam logic [4:0] POS_MON1 = 5'd1;
    localparam logic [4:0] POS_MON2 = 5'd2;
    localparam logic [4:0] POS_DAY0 = 5'd4;
    localparam logic [4:0] POS_DAY1 = 5'd5;
    localparam logic [4:0] POS_HR0  = 5'd7;
    localparam logic [4:0] POS_HR1  = 5'd8;
    localparam logic [4:0] POS_MIN0 = 5'd10;
    localparam logic [4:0] POS_MIN1 = 5'd11;
    localparam logic [4:0] POS_SEC0 = 5'd13;
    localparam logic [4:0] POS_SEC1 = 5'd14;
    localparam logic [4:0] POS_YR0  = 5'd16;
    localparam logic [4:0] POS_YR1  = 5'd17;
    localparam logic [4:0] POS_YR2  = 5'd18;
    localparam logic [4:0] POS_YR3  = 5'd19;
    localparam logic [4:0] POS_MAX  = 5'd31;

    function automatic logic [6:0] add_digit7(input logic [6:0] acc, input logic [7:0] ch);
        return 7'(acc * 7'd10) + ch[6:0] - 7'd48;
    endfunction

    function automatic logic [13:0] add_digit14(input logic [13:0] acc, input logic [7:0] ch);
        return 14'(acc * 14'd10) + {6'b0, ch} - 14'd48;
    endfunction

    logic [4:0]  r_pos,   n_pos;
    logic [15:0] r_mname, n_mname;
    logic [3:0]  r_month, n_month;
    logic [6:0]  r_day,   n_day;
    logic [6:0]  r_hour,  n_hour;
    logic [6:0]  r_min,   n_min;
    logic [6:0]  r_sec,   n_sec;
    logic [13:0] r_year,  n_year;
    logic        w_end;

    always_comb begin
        n_pos   = r_pos;
        n_mname = r_mname;
        n_month = r_month;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_year  = r_year;
        if (i_accept) begin
            case (r_pos)
                POS_MON0: n_mname = {i_item.character, 8'h00};
                POS_MON1: n_mname = {r_mname[15:8], i_item.character};
                POS_MON2: n_month = month_lookup(r_mname[15:8], r_mname[7:0],
                                                 i_item.character);
                POS_DAY0, POS_DAY1: n_day  = add_digit7(r_day, i_item.character);
                POS_HR0,  POS_HR1:  n_hour = add_digit7(r_hour, i_item.character);
                POS_MIN0, POS_MIN1: n_min  = add_digit7(r_min, i_item.character);
                POS_SEC0, POS_SEC1: n_sec  = add_digit7(r_sec, i_item.character);
                POS_YR0, POS_YR1, POS_YR2, POS_YR3:
                    n_year = add_digit14(r_year, i_item.character);
                default: ;
            endcase
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    assign w_end  = i_accept && i_item.last;
    assign o_push = w_end;

    always_comb begin
        o_job.year   = n_year;
        o_job.month  = n_month;
        o_job.day    = n_day;
        o_job.hour   = n_hour;
        o_job.minute = n_min;
        o_job.second = n_sec;
        // only a text that ends on its twentieth character is well formed
        o_job.bad    = (r_pos != POS_YR3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_pos   <= '0;
            r_mname <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_year  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_mname <= n_mname;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_year  <= n_year;
        end
    end

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (r_pos == POS_MON0) && (r_year == '0) && (r_month == MON_NONE))
        else $error("text state not cleared after final beat");

endmodule

### design/dtes_queue.sv
module dtes_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dtes_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output dtes_pkg::t_job o_job
);
    import dtes_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2) || i_pop)
        else $error("job queue overflow");

endmodule

### design/dtes_back.sv
module dtes_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_offset,
    input  logic                 i_job_valid,
    input  dtes_pkg::t_job       i_job,
    output logic                 o_job_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output dtes_pkg::t_out_item  o_result
);
    import dtes_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CAL  = 3'd2;
    localparam logic [2:0] S_DAYS = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;

    // x/25 == (x*1311) >> 15 for every x below 4096
    localparam logic [10:0]       RECIP25     = 11'd1311;
    localparam logic [13:0]       YEAR_LEAP0  = 14'd2000;
    localparam logic signed [15:0] BASE_YEAR  = 16'sd1999;
    localparam logic signed [13:0] BASE_LEAPS = 14'sd484;

    logic [2:0]  r_state, n_state;
    t_job        r_job, n_job;
    logic [22:0] r_p100, n_p100;
    logic [20:0] r_p400, n_p400;
    logic [22:0] r_py,   n_py;
    logic signed [13:0] r_lp, n_lp;
    logic [8:0]  r_mdays, n_mdays;
    logic signed [24:0] r_ybase, n_ybase;
    logic signed [24:0] r_days, n_days;
    logic [18:0] r_tod, n_tod;
    logic signed [41:0] r_prod, n_prod;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [13:0] w_n;
    logic [7:0]  w_d100;
    logic [5:0]  w_d400;
    logic [7:0]  w_yq25;
    logic [11:0] w_r25;
    logic        w_leap;
    logic signed [13:0] w_lp;
    logic signed [15:0] w_ydiff;
    logic signed [24:0] w_ydiff_ext;
    logic signed [24:0] w_lp_ext;
    logic signed [41:0] w_days_ext;
    logic signed [41:0] w_sum;
    logic        w_out_free;

    assign w_n    = r_job.year - 14'd1;
    assign w_d100 = r_p100[22:15];
    assign w_d400 = r_p400[20:15];
    assign w_yq25 = r_py[22:15];
    assign w_r25  = r_job.year[13:2] - 12'({4'b0, w_yq25} * 12'd25);
    // divisible by 4, and not by 100 unless by 400
    assign w_leap = (r_job.year[1:0] == 2'b00) && ((w_r25 != '0) || (r_job.year[3:0] == 4'h0));
    assign w_lp   = $signed({2'b00, w_n[13:2]}) - $signed({6'b0, w_d100})
                  + $signed({8'b0, w_d400}) - BASE_LEAPS;
    assign w_ydiff     = $signed({2'b00, r_job.year}) - BASE_YEAR;
    assign w_ydiff_ext = w_ydiff;
    assign w_lp_ext    = r_lp;
    assign w_days_ext  = r_days;
    assign w_sum       = r_prod + $signed({23'b0, r_tod}) - $signed({10'b0, i_offset});
    assign w_out_free  = !r_out_valid || i_pop;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_p100      = r_p100;
        n_p400      = r_p400;
        n_py        = r_py;
        n_lp        = r_lp;
        n_mdays     = r_mdays;
        n_ybase     = r_ybase;
        n_days      = r_days;
        n_tod       = r_tod;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_p100  = 23'(w_n[13:2]) * 23'(RECIP25);
                n_p400  = 21'(w_n[13:4]) * 21'(RECIP25);
                n_py    = 23'(r_job.year[13:2]) * 23'(RECIP25);
                n_state = S_CAL;
            end
            S_CAL: begin
                n_lp    = (r_job.year > YEAR_LEAP0) ? w_lp : 14'sd0;
                n_mdays = days_before(r_job.month)
                        + {8'b0, (r_job.month >= MON_MAR) && (r_job.month <= MON_DEC) && w_leap};
                n_ybase = w_ydiff_ext * 25'sd365;
                n_state = S_DAYS;
            end
            S_DAYS: begin
                n_days  = r_ybase + w_lp_ext + $signed({16'b0, r_mdays})
                        + $signed({18'b0, r_job.day}) - 25'sd1;
                n_tod   = 19'(r_job.second) + 19'(r_job.minute) * 19'd60
                        + 19'(r_job.hour) * 19'd3600;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = w_days_ext * 42'sd86400;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (w_out_free) begin
                    if (r_job.bad) begin
                        n_out.seconds = '0;
                        n_out.status  = STATUS_BAD_LENGTH;
                    end else begin
                        n_out.seconds = w_sum[40:0];
                        n_out.status  = STATUS_OK;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_p100  <= n_p100;
        r_p400  <= n_p400;
        r_py    <= n_py;
        r_lp    <= n_lp;
        r_mdays <= n_mdays;
        r_ybase <= n_ybase;
        r_days  <= n_days;
        r_tod   <= n_tod;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == STATUS_BAD_LENGTH) |-> (r_out.seconds == '0))
        else $error("bad length result carries nonzero seconds");

    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) && !w_out_free |=> (r_state == S_SUM))
        else $error("final sum left while result register occupied");

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == S_DIV))
        else $error("job taken without starting the sequence");

endmodule

### design/date_text_to_epoch_seconds_core.sv
// channel   direction  handshake            payload
// text      in         push / full          i_item     (character, last)
// result    out        empty / pop          o_result   (seconds, status)
// config    in         psel/penable/pwrite  paddr, pwdata, prdata (epoch_offset at 0)
//
// characters are taken one per cycle while full is low; a text's fields are parsed
// as they arrive; the final beat hands the parsed text to a two-entry queue; the
// arithmetic sequencer then takes one text at a time through load, reciprocal
// multiplies, leap and month days, day sum, scale by 86400, final add and offset
// reset is synchronous, with i_rst_n low; no clearing pass
// full rises only while the queue holds two texts; a held result stalls the sequencer
module date_text_to_epoch_seconds_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  dtes_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output dtes_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import dtes_pkg::*;

    logic        r_offset;
    logic [31:0] r_epoch_offset;
    logic        w_accept;
    logic        w_push;
    t_job        w_front_job;
    logic        w_job_valid;
    logic        w_job_pop;
    t_job        w_job;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : r_epoch_offset;
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_offset <= EPOCH_OFFSET_RST;
            r_offset       <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_epoch_offset <= pwdata;
            end
            // marks that the offset has been written since reset
            r_offset <= r_offset || w_cfg_wr;
        end
    end

    dtes_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_push),
        .o_job    (w_front_job)
    );

    dtes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (full),
        .o_valid (w_job_valid),
        .i_pop   (w_job_pop),
        .o_job   (w_job)
    );

    dtes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_offset    (r_epoch_offset),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    a_offset_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_offset |-> (r_epoch_offset == EPOCH_OFFSET_RST))
        else $error("epoch offset changed without a write");

endmodule

### test/epoch_seconds_checker.sv
`timescale 1ns / 100ps

module epoch_seconds_checker
    import dtes_pkg::*;
#(
    parameter logic [2:0] OFFSET_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_item    i_item,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out_item   i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    localparam int     TEXT_LEN   = 20;
    localparam longint FIRST_YEAR = 1999;
    localparam longint SECS_DAY   = 86400;
    localparam logic [8*36-1:0] MONTH_ABBR = "JanFebMarAprMayJunJulAugSepOctNovDec";

    logic [31:0] epoch_offset;
    logic [4:0]  char_pos;
    logic [15:0] month_chars;
    logic [3:0]  month_num;
    logic [6:0]  day_v;
    logic [6:0]  hour_v;
    logic [6:0]  min_v;
    logic [6:0]  sec_v;
    logic [13:0] year_v;
    t_out_item   expected_seconds_q[$];

    initial o_errors = 0;
    initial o_pending = 0;

    function automatic logic [3:0] decode_month(input logic [23:0] name);
        logic [3:0] m;
        m = MON_NONE;
        for (int k = 0; k < 12; k++)
            if (MONTH_ABBR[8*36-1-24*k -: 24] == name) m = 4'(k + 1);
        return m;
    endfunction

    function automatic bit is_leap(input longint y);
        return (y % 4 == 0) && ((y % 25 != 0) || (y % 16 == 0));
    endfunction

    function automatic longint leaps_through(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic logic signed [40:0] predict_epoch_seconds();
        longint y, md, yd, total;
        y  = year_v;
        md = 0;
        if (month_num >= MON_JAN && month_num <= MON_DEC) begin
            for (int k = 1; k < month_num; k++)
                md += (k == MON_FEB) ? 28 :
                      (k == MON_APR || k == MON_JUN || k == MON_SEP || k == MON_NOV) ? 30 : 31;
            if (month_num >= MON_MAR && is_leap(y)) md++;
        end
        yd = 365 * (y - FIRST_YEAR);
        if (y > 2000) yd += leaps_through(y - 1) - leaps_through(FIRST_YEAR);
        total = longint'(sec_v) + longint'(min_v) * 60 + longint'(hour_v) * 3600
              + (longint'(day_v) - 1) * SECS_DAY + (md + yd) * SECS_DAY
              - longint'(epoch_offset);
        return total[40:0];
    endfunction

    task clear_text();
        char_pos    = '0;
        month_chars = '0;
        month_num   = MON_NONE;
        day_v       = '0;
        hour_v      = '0;
        min_v       = '0;
        sec_v       = '0;
        year_v      = '0;
    endtask

    task take_char(input logic [7:0] ch, input logic lst);
        logic [4:0] p;
        t_out_item  r;
        p = char_pos;
        case (p)
            5'd0: month_chars = {ch, 8'h00};
            5'd1: month_chars[7:0] = ch;
            5'd2: month_num = decode_month({month_chars, ch});
            5'd4, 5'd5: day_v = 7'(day_v * 10 + ch - 48);
            5'd7, 5'd8: hour_v = 7'(hour_v * 10 + ch - 48);
            5'd10, 5'd11: min_v = 7'(min_v * 10 + ch - 48);
            5'd13, 5'd14: sec_v = 7'(sec_v * 10 + ch - 48);
            5'd16, 5'd17, 5'd18, 5'd19: year_v = 14'(year_v * 10 + ch - 48);
            default: ;
        endcase
        if (char_pos != 5'd31) char_pos++;
        if (lst) begin
            if (p == TEXT_LEN - 1) begin
                r.seconds = predict_epoch_seconds();
                r.status  = STATUS_OK;
            end else begin
                r.seconds = '0;
                r.status  = STATUS_BAD_LENGTH;
            end
            expected_seconds_q.push_back(r);
            clear_text();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            epoch_offset = EPOCH_OFFSET_RST;
            clear_text();
            expected_seconds_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_seconds_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("checker: result beat with nothing expected: seconds %0d status %0d",
                                 i_result.seconds, i_result.status);
                end else begin
                    want = expected_seconds_q.pop_front();
                    if (i_result.seconds !== want.seconds || i_result.status !== want.status) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("checker: mismatch: expected seconds %0d status %0d, got seconds %0d status %0d",
                                     want.seconds, want.status, i_result.seconds, i_result.status);
                    end
                end
            end
            if (i_push && !i_full) take_char(i_item.character, i_item.last);
            if (i_psel && i_penable && i_pready && i_paddr == OFFSET_ADDR) begin
                if (i_pwrite) begin
                    epoch_offset = i_pwdata;
                end else if (i_prdata !== epoch_offset) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("checker: offset read mismatch: expected %0d, got %0d",
                                 epoch_offset, i_prdata);
                end
            end
        end
        o_pending = expected_seconds_q.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import dtes_pkg::*;

    localparam logic [2:0] OFFSET_ADDR  = 3'd0;
    localparam int         TEXT_LEN     = 20;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         QUIET_LIMIT  = 5000;
    localparam logic [8*36-1:0] MONTH_TEXT = "JanFebMarAprMayJunJulAugSepOctNovDec";

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    t_in_item    i_item  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_out_item   o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles      = 0;

    logic [7:0] text_buf [0:39];
    int         text_len;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    date_text_to_epoch_seconds_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    epoch_seconds_checker #(.OFFSET_ADDR(OFFSET_ADDR)) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_full   (full),
        .i_item   (i_item),
        .i_empty  (empty),
        .i_pop    (pop),
        .i_result (o_result),
        .i_psel   (psel),
        .i_penable(penable),
        .i_pwrite (pwrite),
        .i_paddr  (paddr),
        .i_pwdata (pwdata),
        .i_prdata (prdata),
        .i_pready (pready),
        .o_errors (errors),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: any accepted beat or register access counts as progress
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task set_idling(input int mode);
        sender_idle_pct    = (mode == 1) ? 61 : (mode == 3) ? 6 : 0;
        receiver_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 6 : 0;
    endtask

    task send_char(input logic [7:0] ch, input logic lst);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_item.character <= ch;
        i_item.last      <= lst;
        do @(posedge i_clk); while (full);
    endtask

    task send_text();
        for (int i = 0; i < text_len; i++)
            send_char(text_buf[i], i == text_len - 1);
    endtask

    task load_text(input string s);
        text_len = s.len();
        for (int i = 0; i < text_len; i++)
            text_buf[i] = s[i];
    endtask

    task put_digits(input int at, input int value, input int ndig);
        for (int k = ndig - 1; k >= 0; k--) begin
            text_buf[at + k] = 8'("0") + 8'(value % 10);
            value = value / 10;
        end
    endtask

    task apb_access(input logic wr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= OFFSET_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // let all results come back and the arithmetic pipe go quiet
    task drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task make_random_text();
        int roll, mon, yr;
        roll = $urandom_range(99);
        if (roll < 75) begin
            text_len = TEXT_LEN;
            mon = $urandom_range(11);
            for (int k = 0; k < 3; k++)
                text_buf[k] = MONTH_TEXT[8*36-1-8*(3*mon+k) -: 8];
            if ($urandom_range(9) == 0) text_buf[$urandom_range(2)] = 8'($urandom_range(65, 122));
            text_buf[3]  = " ";
            text_buf[6]  = " ";
            text_buf[9]  = ":";
            text_buf[12] = ":";
            text_buf[15] = " ";
            put_digits(4, ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(1, 31), 2);
            put_digits(7, ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(23), 2);
            put_digits(10, ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(59), 2);
            put_digits(13, ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(59), 2);
            roll = $urandom_range(9);
            yr = (roll < 7) ? $urandom_range(1999, 2105) :
                 (roll < 9) ? $urandom_range(1900, 2500) : $urandom_range(9999);
            put_digits(16, yr, 4);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 2)) text_buf[$urandom_range(19)] = 8'($urandom);
        end else if (roll < 87) begin
            text_len = $urandom_range(1, 39);
            if (text_len == TEXT_LEN) text_len++;
            for (int i = 0; i < text_len; i++)
                text_buf[i] = $urandom_range(1) ? 8'($urandom_range(48, 57)) : 8'($urandom);
        end else begin
            text_len = TEXT_LEN;
            for (int i = 0; i < text_len; i++)
                text_buf[i] = 8'($urandom);
        end
    endtask

    initial begin
        logic [31:0] offset;
        int          sent_items;
        int          texts;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, '0);

        // directed texts with the offset at its reset value
        set_idling(0);
        load_text("Jan 01 00:00:00 1999"); send_text();
        load_text("Dec 31 23:59:59 2099"); send_text();
        load_text("Feb 29 12:34:56 2000"); send_text();
        load_text("Mar 01 00:00:00 2100"); send_text();
        load_text("Mar 01 00:00:00 2400"); send_text();
        load_text("Xyz 15 10:10:10 2020"); send_text();
        load_text("jan 15 10:10:10 2020"); send_text();
        load_text("Apr 00 00:00:00 1998"); send_text();
        load_text("May 01 00:00:00 0000"); send_text();
        load_text("Jun AB CD:EF:GH IJKL"); send_text();
        load_text("Oct 10 99:99:99 9999"); send_text();
        // all-zero and all-one characters in number and separator slots
        load_text("Jul 04 12:00:00 2024");
        text_buf[3]  = 8'hFF;
        text_buf[4]  = 8'h00;
        text_buf[19] = 8'hFF;
        send_text();
        load_text("A"); send_text();
        load_text("Aug 01 00:00:00 201"); send_text();
        load_text("Sep 01 00:00:00 20155"); send_text();
        // long enough to pin the position counter
        text_len = 35;
        for (int i = 0; i < text_len; i++) text_buf[i] = "7";
        send_text();

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0:       offset = '0;
                1:       offset = '1;
                4:       offset = EPOCH_OFFSET_RST;
                default: offset = $urandom;
            endcase
            apb_access(1'b1, offset);
            apb_access(1'b0, '0);
            set_idling((ph + 1) % 4);
            sent_items = 0;
            texts      = 0;
            while (sent_items < 40 || texts < 2) begin
                make_random_text();
                send_text();
                sent_items += text_len;
                texts++;
            end
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### date_text_to_epoch_seconds_core.f
design/dtes_pkg.sv
design/dtes_front.sv
design/dtes_queue.sv
design/dtes_back.sv
design/date_text_to_epoch_seconds_core.sv
test/epoch_seconds_checker.sv
test/tb.sv
